// ===== design/slm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slm_pkg
// Shared constants and tables of the sphere logarithm map pipeline.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int unsigned FRAC_BITS    = 14;  // fraction bits of ports
  localparam int unsigned IN_W         = 16;
  localparam int unsigned TAN_W        = 18;
  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned ANG_BITS     = 20;  // internal angle fraction bits
  localparam int unsigned ANG_SHIFT    = ANG_BITS - FRAC_BITS;
  localparam int unsigned CORDIC_STEPS = 21;
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned DIV_STEPS    = 17;
  localparam int unsigned NORM_TOP     = 29;  // normalized leading bit
  localparam int unsigned ANGLE_LIMIT  = 51472;

  localparam logic [21:0] PI_ANG = 22'd3294199;

  // arctan(2^-i) with ANG_BITS fraction bits
  localparam logic [19:0] ATAN_TBL [CORDIC_STEPS] = '{
    20'd823550, 20'd486170, 20'd256879, 20'd130396, 20'd65451, 20'd32757,
    20'd16383, 20'd8192, 20'd4096, 20'd2048, 20'd1024, 20'd512, 20'd256,
    20'd128, 20'd64, 20'd32, 20'd16, 20'd8, 20'd4, 20'd2, 20'd1
  };

  typedef struct packed {
    logic [61:0] rad;
    logic [30:0] c;
    logic        neg;
  } slm_ang_t;

  typedef struct packed {
    logic [62:0]      va;
    logic [62:0]      ra;
    logic [62:0]      vb;
    logic [62:0]      rb;
    logic [30:0]      c;
    logic             neg;
    logic [2:0][29:0] q;
    logic [2:0]       psign;
    logic             degen;
  } slm_sq_t;

  typedef struct packed {
    logic [33:0]      x;
    logic [33:0]      y;
    logic [23:0]      z;
    logic             neg;
    logic [30:0]      n;
    logic [2:0][29:0] q;
    logic [2:0]       psign;
    logic             degen;
  } slm_cr_t;

  typedef struct packed {
    logic [2:0][53:0] rem;
    logic [2:0][16:0] quo;
    logic [36:0]      den;
    logic [15:0]      ang;
    logic [2:0]       psign;
    logic             degen;
  } slm_dv_t;

endpackage

// ===== design/sphere_logarithm_map_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_logarithm_map_top
// Logarithm map on the unit sphere: tangent vector and geodesic angle.
// ----------------------------------------------------------------------------
// One request per cycle goes in and one result per cycle comes out while the
// output is not stalled. Each request passes through the pipelined units:
// ten front stages (products, sums, clamp and rounding, squares, projection,
// normalization), two 32-step square roots run side by side (sin of the angle
// and norm of the projected vector), 21 CORDIC vectoring steps for atan2,
// one angle finish stage, one multiply stage and three 17-step restoring
// dividers, then the output register. The whole pipe advances together; it
// holds only while a result sits in the output register and out_stall_i is
// high, and in_stall_o is raised exactly then. Equal or antipodal points
// give a zero tangent with degenerate_o set; the angle is still reported.
module sphere_logarithm_map_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [slm_pkg::IN_W-1:0]     base_x_i,
  input  logic signed [slm_pkg::IN_W-1:0]     base_y_i,
  input  logic signed [slm_pkg::IN_W-1:0]     base_z_i,
  input  logic signed [slm_pkg::IN_W-1:0]     target_x_i,
  input  logic signed [slm_pkg::IN_W-1:0]     target_y_i,
  input  logic signed [slm_pkg::IN_W-1:0]     target_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [slm_pkg::TAN_W-1:0]    tangent_x_o,
  output logic signed [slm_pkg::TAN_W-1:0]    tangent_y_o,
  output logic signed [slm_pkg::TAN_W-1:0]    tangent_z_o,
  output logic        [slm_pkg::ANGLE_W-1:0]  geodesic_angle_o,
  output logic                                degenerate_o
);
  import slm_pkg::*;

  // stage map
  localparam int unsigned FRONT = 10;
  localparam int unsigned SQ0   = FRONT;
  localparam int unsigned CR0   = SQ0 + SQRT_STEPS;
  localparam int unsigned ZF    = CR0 + CORDIC_STEPS + 1;
  localparam int unsigned MUL   = ZF + 1;
  localparam int unsigned DV0   = MUL;
  localparam int unsigned LAT   = DV0 + DIV_STEPS + 1;

  localparam logic [32:0] ONE_DOT = 33'(1) << (2 * FRAC_BITS);

  // --------------------------------------------------------------------------
  // Flow control: one shared advance for the whole pipe
  // --------------------------------------------------------------------------
  logic           ce;
  logic [LAT:1]   v_q;

  assign ce         = !v_q[LAT] || !out_stall_i;
  assign in_stall_o = !ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ce) begin
      v_q <= {v_q[LAT-1:1], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Front stages 1..5: dot products, clamp, projection coefficient
  // --------------------------------------------------------------------------
  logic signed [15:0] b_in [3];
  logic signed [15:0] t_in [3];

  assign b_in[0] = base_x_i;
  assign b_in[1] = base_y_i;
  assign b_in[2] = base_z_i;
  assign t_in[0] = target_x_i;
  assign t_in[1] = target_y_i;
  assign t_in[2] = target_z_i;

  logic signed [15:0] b1_q [3];
  logic signed [16:0] d1_q [3];
  logic signed [31:0] bt1_q [3];
  logic signed [32:0] bd1_q [3];

  logic signed [15:0] b2_q [3];
  logic signed [16:0] d2_q [3];
  logic signed [32:0] dot2_q;
  logic signed [34:0] bds2_q;

  logic signed [15:0] b3_q [3];
  logic signed [16:0] d3_q [3];
  logic        [30:0] c3_q;
  logic               neg3_q;
  logic signed [20:0] k3_q;

  logic signed [16:0] d4_q [3];
  logic signed [36:0] kb4_q [3];
  logic        [61:0] csq4_q;
  logic        [30:0] c4_q;
  logic               neg4_q;

  logic signed [37:0] p5_q [3];
  logic        [61:0] rad5_q;
  logic        [30:0] c5_q;
  logic               neg5_q;

  logic signed [16:0] d1_d [3];
  logic        [32:0] dm3;
  logic        [32:0] dmc3;
  logic        [34:0] bm3;
  logic        [20:0] kr3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_d[i] = 17'(t_in[i]) - 17'(b_in[i]);
    end
    dm3  = dot2_q[32] ? 33'(-dot2_q) : 33'(dot2_q);
    dmc3 = (dm3 > ONE_DOT) ? ONE_DOT : dm3;
    bm3  = bds2_q[34] ? 35'(-bds2_q) : 35'(bds2_q);
    kr3  = 21'((bm3 + (35'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        b1_q[i]  <= b_in[i];
        d1_q[i]  <= d1_d[i];
        bt1_q[i] <= b_in[i] * t_in[i];
        bd1_q[i] <= 33'(b_in[i]) * 33'(d1_d[i]);
        b2_q[i]  <= b1_q[i];
        d2_q[i]  <= d1_q[i];
        b3_q[i]  <= b2_q[i];
        d3_q[i]  <= d2_q[i];
        d4_q[i]  <= d3_q[i];
        kb4_q[i] <= 37'(k3_q) * 37'(b3_q[i]);
        p5_q[i]  <= (38'(d4_q[i]) <<< FRAC_BITS) - 38'(kb4_q[i]);
      end
      dot2_q <= 33'(bt1_q[0]) + 33'(bt1_q[1]) + 33'(bt1_q[2]);
      bds2_q <= 35'(bd1_q[0]) + 35'(bd1_q[1]) + 35'(bd1_q[2]);
      c3_q   <= 31'(dmc3 << (30 - 2 * FRAC_BITS));
      neg3_q <= dot2_q[32];
      k3_q   <= bds2_q[34] ? -$signed(kr3) : $signed(kr3);
      csq4_q <= 62'(c3_q) * 62'(c3_q);
      c4_q   <= c3_q;
      neg4_q <= neg3_q;
      rad5_q <= (62'(1) << 60) - csq4_q;
      c5_q   <= c4_q;
      neg5_q <= neg4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Front stages 6..10: magnitudes, block normalization, sum of squares
  // --------------------------------------------------------------------------
  slm_ang_t           ad_q [6:10];
  logic        [37:0] m6_q [3];
  logic        [2:0]  ps6_q;
  logic        [37:0] m7_q [3];
  logic        [5:0]  l7_q;
  logic        [2:0]  ps7_q;
  logic               dg7_q;
  logic [2:0][29:0]   q8_q;
  logic        [2:0]  ps8_q;
  logic               dg8_q;
  logic        [59:0] qq9_q [3];
  logic [2:0][29:0]   q9_q;
  logic        [2:0]  ps9_q;
  logic               dg9_q;
  logic        [61:0] ss10_q;
  logic [2:0][29:0]   q10_q;
  logic        [2:0]  ps10_q;
  logic               dg10_q;

  logic [37:0]      orv6;
  logic [5:0]       lead6;
  logic [2:0][29:0] q7;

  always_comb begin
    orv6  = m6_q[0] | m6_q[1] | m6_q[2];
    lead6 = '0;
    for (int i = 0; i < 38; i++) begin
      if (orv6[i]) begin
        lead6 = 6'(i);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (l7_q >= 6'(NORM_TOP)) begin
        q7[i] = 30'(m7_q[i] >> (l7_q - 6'(NORM_TOP)));
      end else begin
        q7[i] = 30'(m7_q[i] << (6'(NORM_TOP) - l7_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      ad_q[6] <= '{rad: rad5_q, c: c5_q, neg: neg5_q};
      for (int k = 7; k <= 10; k++) begin
        ad_q[k] <= ad_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        m6_q[i]  <= p5_q[i][37] ? 38'(-p5_q[i]) : 38'(p5_q[i]);
        ps6_q[i] <= p5_q[i][37];
        m7_q[i]  <= m6_q[i];
        qq9_q[i] <= 60'(q8_q[i]) * 60'(q8_q[i]);
      end
      l7_q   <= lead6;
      ps7_q  <= ps6_q;
      dg7_q  <= (orv6 == '0);
      q8_q   <= q7;
      ps8_q  <= ps7_q;
      dg8_q  <= dg7_q;
      q9_q   <= q8_q;
      ps9_q  <= ps8_q;
      dg9_q  <= dg8_q;
      ss10_q <= 62'(qq9_q[0]) + 62'(qq9_q[1]) + 62'(qq9_q[2]);
      q10_q  <= q9_q;
      ps10_q <= ps9_q;
      dg10_q <= dg9_q;
    end
  end

  // --------------------------------------------------------------------------
  // Two digit-by-digit square roots, one step per stage
  //   a: sqrt(2^60 - c^2), sine of the angle
  //   b: sqrt(sum q^2), norm of the normalized projection
  // --------------------------------------------------------------------------
  slm_sq_t sq_s [0:SQRT_STEPS];
  slm_sq_t sq_q [1:SQRT_STEPS];

  assign sq_s[0] = '{va: {1'b0, ad_q[10].rad}, ra: '0, vb: {1'b0, ss10_q}, rb: '0,
                     c: ad_q[10].c, neg: ad_q[10].neg, q: q10_q, psign: ps10_q,
                     degen: dg10_q};

  for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [62:0] BitW = 63'(1) << (2 * (SQRT_STEPS - j));
    slm_sq_t sq_d;

    always_comb begin
      sq_d = sq_s[j-1];
      if (sq_d.va >= sq_d.ra + BitW) begin
        sq_d.va = sq_d.va - (sq_d.ra + BitW);
        sq_d.ra = (sq_d.ra >> 1) + BitW;
      end else begin
        sq_d.ra = sq_d.ra >> 1;
      end
      if (sq_d.vb >= sq_d.rb + BitW) begin
        sq_d.vb = sq_d.vb - (sq_d.rb + BitW);
        sq_d.rb = (sq_d.rb >> 1) + BitW;
      end else begin
        sq_d.rb = sq_d.rb >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        sq_q[j] <= sq_d;
      end
    end

    assign sq_s[j] = sq_q[j];
  end

  // --------------------------------------------------------------------------
  // CORDIC vectoring: atan2(s, |c|), one rotation per stage
  // --------------------------------------------------------------------------
  slm_cr_t cr_s [0:CORDIC_STEPS];
  slm_cr_t cr_q [1:CORDIC_STEPS];

  assign cr_s[0] = '{x: {3'b000, sq_s[SQRT_STEPS].c},
                     y: {3'b000, sq_s[SQRT_STEPS].ra[30:0]},
                     z: '0, neg: sq_s[SQRT_STEPS].neg,
                     n: sq_s[SQRT_STEPS].rb[30:0], q: sq_s[SQRT_STEPS].q,
                     psign: sq_s[SQRT_STEPS].psign, degen: sq_s[SQRT_STEPS].degen};

  for (genvar j = 1; j <= CORDIC_STEPS; j++) begin : g_cordic
    localparam int unsigned Sh = j - 1;
    slm_cr_t            cr_d;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [23:0] zs;
    logic signed [23:0] at;

    always_comb begin
      cr_d = cr_s[j-1];
      xs   = $signed(cr_s[j-1].x);
      ys   = $signed(cr_s[j-1].y);
      zs   = $signed(cr_s[j-1].z);
      dx   = ys >>> Sh;
      dy   = xs >>> Sh;
      at   = $signed({4'b0000, ATAN_TBL[Sh]});
      if (ys > 0) begin
        cr_d.x = xs + dx;
        cr_d.y = ys - dy;
        cr_d.z = zs + at;
      end else begin
        cr_d.x = xs - dx;
        cr_d.y = ys + dy;
        cr_d.z = zs - at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        cr_q[j] <= cr_d;
      end
    end

    assign cr_s[j] = cr_q[j];
  end

  // --------------------------------------------------------------------------
  // Angle finish: fold for negative dot, clamp to [0, pi], round to port
  // --------------------------------------------------------------------------
  logic        [21:0]   zf_q;
  logic        [15:0]   angf_q;
  logic        [30:0]   nf_q;
  logic [2:0][29:0]     qf_q;
  logic        [2:0]    psf_q;
  logic                 dgf_q;

  logic signed [23:0] zt;
  logic        [21:0] zc;

  always_comb begin
    if (cr_s[CORDIC_STEPS].neg) begin
      zt = $signed({2'b00, PI_ANG}) - $signed(cr_s[CORDIC_STEPS].z);
    end else begin
      zt = $signed(cr_s[CORDIC_STEPS].z);
    end
    if (zt < 0) begin
      zc = '0;
    end else if (zt > $signed({2'b00, PI_ANG})) begin
      zc = PI_ANG;
    end else begin
      zc = zt[21:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      zf_q   <= zc;
      angf_q <= 16'((23'(zc) + (23'(1) << (ANG_SHIFT - 1))) >> ANG_SHIFT);
      nf_q   <= cr_s[CORDIC_STEPS].n;
      qf_q   <= cr_s[CORDIC_STEPS].q;
      psf_q  <= cr_s[CORDIC_STEPS].psign;
      dgf_q  <= cr_s[CORDIC_STEPS].degen;
    end
  end

  // --------------------------------------------------------------------------
  // Scale: numerator angle * q with rounding half of the divisor
  // --------------------------------------------------------------------------
  slm_dv_t dv_s [0:DIV_STEPS];
  slm_dv_t dv_q [1:DIV_STEPS];
  slm_dv_t mul_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        mul_q.rem[i] <= 54'(zf_q) * 54'(qf_q[i]) + (54'(nf_q) << (ANG_SHIFT - 1));
        mul_q.quo[i] <= '0;
      end
      mul_q.den   <= 37'(nf_q) << ANG_SHIFT;
      mul_q.ang   <= angf_q;
      mul_q.psign <= psf_q;
      mul_q.degen <= dgf_q;
    end
  end

  assign dv_s[0] = mul_q;

  // restoring division, one quotient bit per stage, MSB first
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    localparam int unsigned Sh = DIV_STEPS - j;
    slm_dv_t     dv_d;
    logic [54:0] trial [3];

    always_comb begin
      dv_d = dv_s[j-1];
      for (int i = 0; i < 3; i++) begin
        trial[i] = {1'b0, dv_s[j-1].rem[i]} - ({18'b0, dv_s[j-1].den} << Sh);
        if (!trial[i][54]) begin
          dv_d.rem[i] = trial[i][53:0];
        end
        dv_d.quo[i] = {dv_s[j-1].quo[i][15:0], !trial[i][54]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce) begin
        dv_q[j] <= dv_d;
      end
    end

    assign dv_s[j] = dv_q[j];
  end

  // --------------------------------------------------------------------------
  // Output register; quotient never exceeds the tangent range
  // --------------------------------------------------------------------------
  logic signed [17:0] tan_q [3];
  logic        [15:0] ang_q;
  logic               dg_q;

  always_ff @(posedge clk_i) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_s[DIV_STEPS].degen) begin
          tan_q[i] <= '0;
        end else if (dv_s[DIV_STEPS].psign[i]) begin
          tan_q[i] <= -$signed(18'(dv_s[DIV_STEPS].quo[i]));
        end else begin
          tan_q[i] <= $signed(18'(dv_s[DIV_STEPS].quo[i]));
        end
      end
      ang_q <= dv_s[DIV_STEPS].ang;
      dg_q  <= dv_s[DIV_STEPS].degen;
    end
  end

  assign out_valid_o      = v_q[LAT];
  assign tangent_x_o      = tan_q[0];
  assign tangent_y_o      = tan_q[1];
  assign tangent_z_o      = tan_q[2];
  assign geodesic_angle_o = ang_q;
  assign degenerate_o     = dg_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      tangent_x_o == '0 && tangent_y_o == '0 && tangent_z_o == '0)
    else $error("degenerate result with nonzero tangent");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> geodesic_angle_o <= 16'(ANGLE_LIMIT))
    else $error("geodesic angle above pi");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(v_q))
    else $error("pipeline moved while stalled");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sphere logarithm map pipeline against a bit-true predictor.
// ----------------------------------------------------------------------------
// Point pairs are driven through the valid/stall request channel. For every
// accepted request the expected tangent, angle and degenerate flag are worked
// out in integer arithmetic and queued. The checker compares each accepted
// result field by field with the oldest queued expectation.
// The sequence is: directed corner cases, then random pairs under three
// idling mixes, then one long output hold-off that fills the pipe.
// ----------------------------------------------------------------------------
module testbench;
  import slm_pkg::*;

  localparam int PIPE_DEPTH  = 83;
  localparam int STALL_LIMIT = 4000;
  localparam int ONE_Q14     = 1 << FRAC_BITS;

  typedef struct {
    logic signed [TAN_W-1:0]   tx;
    logic signed [TAN_W-1:0]   ty;
    logic signed [TAN_W-1:0]   tz;
    logic        [ANGLE_W-1:0] angle;
    logic                      degen;
  } log_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [IN_W-1:0] base_x_i = '0, base_y_i = '0, base_z_i = '0;
  logic signed [IN_W-1:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [TAN_W-1:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic [ANGLE_W-1:0] geodesic_angle_o;
  logic degenerate_o;

  log_result_t expected_logs[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_output = 1'b0;

  sphere_logarithm_map_top u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- predictor ----------------------------------------------------------
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // floor shift right for signed values (arithmetic shift floors already)
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // acos of the dot product (2*FRAC_BITS fraction bits), angle in Q20
  function automatic longint acos_q20(longint dot);
    longint unsigned dm, c, s;
    longint x, y, z, dx, dy;
    bit neg;
    neg = dot < 0;
    dm = neg ? -dot : dot;
    z = 0;
    if (dm > (64'd1 << (2 * FRAC_BITS))) dm = 64'd1 << (2 * FRAC_BITS);
    c = dm << (30 - 2 * FRAC_BITS);
    s = int_sqrt((64'd1 << 60) - c * c);
    x = c;
    y = s;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    if (neg) z = longint'(PI_ANG) - z;
    if (z < 0) z = 0;
    if (z > longint'(PI_ANG)) z = PI_ANG;
    return z;
  endfunction

  function automatic log_result_t predict_log(longint b[3], longint t[3]);
    log_result_t r;
    longint d[3], p[3], dot, bd, k, z, bdm;
    longint unsigned m[3], mx, n, num, den, q, ang;
    dot = 0;
    bd = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = t[i] - b[i];
      dot += b[i] * t[i];
      bd += b[i] * d[i];
    end
    z = acos_q20(dot);
    ang = (z + (1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
    if (ang > 65535) ang = 65535;
    r.angle = ang[ANGLE_W-1:0];
    // projection scale, rounded half away from zero
    bdm = bd < 0 ? -bd : bd;
    bdm = (bdm + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
    k = bd < 0 ? -bdm : bdm;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      p[i] = d[i] * ONE_Q14 - k * b[i];
      m[i] = p[i] < 0 ? -p[i] : p[i];
      if (m[i] > mx) mx = m[i];
    end
    r.tx = '0; r.ty = '0; r.tz = '0;
    r.degen = (mx == 0);
    if (r.degen) return r;
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    n = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    den = n << ANG_SHIFT;
    for (int i = 0; i < 3; i++) begin
      longint v;
      num = longint'(z) * m[i];
      q = (num + den / 2) / den;
      if (p[i] < 0) begin
        if (q > 131072) q = 131072;
        v = -longint'(q);
      end else begin
        if (q > 131071) q = 131071;
        v = q;
      end
      case (i)
        0: r.tx = v[TAN_W-1:0];
        1: r.ty = v[TAN_W-1:0];
        default: r.tz = v[TAN_W-1:0];
      endcase
    end
    return r;
  endfunction

  // ---- request driver -----------------------------------------------------
  // valid stays high after an accepted request so that the next one can
  // follow back to back; it drops only while the sender idles
  task automatic send_pair(longint bx, longint by, longint bz,
                           longint tx, longint ty, longint tz);
    longint b[3], t[3];
    while (($urandom_range(99, 0)) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    b = '{bx, by, bz};
    t = '{tx, ty, tz};
    base_x_i <= bx[IN_W-1:0]; base_y_i <= by[IN_W-1:0]; base_z_i <= bz[IN_W-1:0];
    target_x_i <= tx[IN_W-1:0]; target_y_i <= ty[IN_W-1:0];
    target_z_i <= tz[IN_W-1:0];
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_logs.push_back(predict_log(b, t));
    @(negedge clk_i);
  endtask

  function automatic longint rand_field();
    return longint'($signed(16'($urandom)));
  endfunction

  // random unit-ish vector component set, scaled near 1.0 in Q2.14
  task automatic rand_unit(output longint v[3]);
    longint unsigned nn;
    longint r[3];
    do begin
      for (int i = 0; i < 3; i++) r[i] = longint'($urandom_range(16383, 0)) - 8192;
      nn = int_sqrt(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]);
    end while (nn < 64);
    for (int i = 0; i < 3; i++) v[i] = (r[i] * ONE_Q14) / longint'(nn);
  endtask

  task automatic send_random(int count);
    longint b[3], t[3];
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(9, 0))
        0: begin  // raw noise over all bits
          for (int i = 0; i < 3; i++) begin
            b[i] = rand_field(); t[i] = rand_field();
          end
        end
        1: begin  // equal points
          rand_unit(b); t = b;
        end
        2: begin  // antipodal points
          rand_unit(b);
          for (int i = 0; i < 3; i++) t[i] = -b[i];
        end
        3: begin  // nearby points, tiny angle
          rand_unit(b);
          for (int i = 0; i < 3; i++) t[i] = b[i] + $urandom_range(8, 0) - 4;
        end
        default: begin
          rand_unit(b); rand_unit(t);
        end
      endcase
      send_pair(b[0], b[1], b[2], t[0], t[1], t[2]);
    end
  endtask

  // ---- result checker -----------------------------------------------------
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_logs.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d a=%0d d=%0d", $time,
                 tangent_x_o, tangent_y_o, tangent_z_o, geodesic_angle_o,
                 degenerate_o);
        error_count++;
      end else begin
        log_result_t e;
        e = expected_logs.pop_front();
        if (e.tx !== tangent_x_o || e.ty !== tangent_y_o || e.tz !== tangent_z_o
            || e.angle !== geodesic_angle_o || e.degen !== degenerate_o) begin
          $display("%0t: mismatch exp x=%0d y=%0d z=%0d a=%0d d=%0d", $time,
                   e.tx, e.ty, e.tz, e.angle, e.degen);
          $display("%0t:          got x=%0d y=%0d z=%0d a=%0d d=%0d", $time,
                   tangent_x_o, tangent_y_o, tangent_z_o, geodesic_angle_o,
                   degenerate_o);
          error_count++;
        end
      end
    end
  end

  // receiver stall: random, or held high during the fill-up test
  always @(negedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_output || ($urandom_range(99, 0) < recv_idle_pct);
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- tests --------------------------------------------------------------
  task automatic test_directed();
    send_pair(ONE_Q14, 0, 0, ONE_Q14, 0, 0);          // equal points
    send_pair(ONE_Q14, 0, 0, -ONE_Q14, 0, 0);         // antipodal points
    send_pair(ONE_Q14, 0, 0, 0, ONE_Q14, 0);          // quarter turn
    send_pair(0, 0, ONE_Q14, 0, -ONE_Q14, 0);
    send_pair(0, ONE_Q14, 0, 11585, 11585, 0);        // 45 degrees
    send_pair(ONE_Q14, 0, 0, -11585, 0, 11585);       // 135 degrees
    send_pair(ONE_Q14, 0, 0, 16383, 181, 0);          // tiny angle
    send_pair(32767, 32767, 32767, 32767, 32767, 32767);     // dot far above 1
    send_pair(-32768, -32768, -32768, 32767, 32767, 32767);  // dot far below -1
    send_pair(32767, 0, 0, 0, -32768, 0);             // non-unit, saturation
    send_pair(-32768, 32767, -32768, 32767, -32768, 32767);
    send_pair(0, 0, 0, 0, 0, 0);                      // zero vectors
    send_pair(0, 0, 0, 32767, -32768, 1);
    send_pair(32767, -32768, 1, 0, 0, 0);
    send_pair(-1, -1, -1, 1, 1, 1);
    send_pair(ONE_Q14, 0, 0, -16383, 181, 0);         // nearly antipodal
  endtask

  task automatic test_random_mix(int send_pct, int recv_pct, int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_random(count);
  endtask

  task automatic test_fill_up();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_output = 1'b1;
    fork
      begin
        // hold off well past the pipe depth while requests keep coming
        repeat (3 * PIPE_DEPTH) @(negedge clk_i);
        hold_output = 1'b0;
      end
      begin
        send_random(120);
        in_valid_i <= 1'b0;
      end
    join
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_mix(18, 69, 140);
    test_random_mix(69, 18, 140);
    test_random_mix(0, 0, 140);
    test_fill_up();
    recv_idle_pct = 0;
    while (expected_logs.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 10) @(negedge clk_i);
    if (error_count == 0 && expected_logs.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
